>>> src/hsst_pkg.sv
// shared types and constants for the http/2 stream state tracker
package hsst_pkg;

    // stream phase codes
    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_OPEN       = 3'd1;
    localparam logic [2:0] PH_RES_LOCAL  = 3'd2;
    localparam logic [2:0] PH_RES_REMOTE = 3'd3;
    localparam logic [2:0] PH_HC_LOCAL   = 3'd4;
    localparam logic [2:0] PH_HC_REMOTE  = 3'd5;
    localparam logic [2:0] PH_CLOSED     = 3'd6;

    // frame event codes
    localparam logic [3:0] ACT_SEND_HDR    = 4'd0;
    localparam logic [3:0] ACT_RECV_HDR    = 4'd1;
    localparam logic [3:0] ACT_SEND_ENDHDR = 4'd2;
    localparam logic [3:0] ACT_RECV_ENDHDR = 4'd3;
    localparam logic [3:0] ACT_SEND_ENDSTR = 4'd4;
    localparam logic [3:0] ACT_RECV_ENDSTR = 4'd5;
    localparam logic [3:0] ACT_SEND_RST    = 4'd6;
    localparam logic [3:0] ACT_RECV_RST    = 4'd7;
    localparam logic [3:0] ACT_DATA        = 4'd8;
    localparam logic [3:0] ACT_CLEAR       = 4'd9;

    // field widths
    localparam int ACTION_W = 4;
    localparam int PAYLEN_W = 24;
    localparam int PHASE_W  = 3;
    localparam int FLAGS_W  = 8;
    localparam int TALLY_W  = 31;

    // counter limit and threshold reset value
    localparam logic [TALLY_W-1:0] TALLY_MAX       = {TALLY_W{1'b1}};
    localparam logic [TALLY_W-1:0] THRESHOLD_RESET = 31'd30000;

    // flag bits feeding headers_complete
    localparam int FLAG_RECV_ENDHDR = 3;
    localparam int FLAG_RECV_ENDSTR = 5;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [TALLY_W-1:0] tally_t;

endpackage

>>> src/http2_stream_state_tracker.sv
// top level: http/2 stream state tracker with received byte counter
//
//  channel | dir | handshake            | beat
//  --------+-----+----------------------+-----------------------------------------
//  s_      | in  | s_valid / s_ready    | action, frame_len
//  m_      | out | m_valid / m_ready    | state, accepted, flags, hc, bytes, wu flag
//  cfg_    | in  | cfg_valid / cfg_ready| window_update_threshold (31 bit)
//
// one beat per cycle sustained unless m_ready is low; input register, then
// next-state table and one 31-bit add/saturate/compare, then result register
// aresetn is synchronous: idle phase, flags and counter zero, threshold 30000
// input stalls only when both the input and result registers hold beats
// and m_ready is low; cfg_ready is always high
module http2_stream_state_tracker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [hsst_pkg::ACTION_W-1:0] s_action,
    input  logic [hsst_pkg::PAYLEN_W-1:0] s_frame_len,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hsst_pkg::PHASE_W-1:0]  m_stream_state,
    output logic                          m_accepted,
    output logic [hsst_pkg::FLAGS_W-1:0]  m_event_flags,
    output logic                          m_headers_complete,
    output logic [hsst_pkg::TALLY_W-1:0]  m_received_bytes,
    output logic                          m_window_update_needed,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [hsst_pkg::TALLY_W-1:0]  cfg_data
);
    import hsst_pkg::*;

    // input register
    logic                in_valid_reg;
    logic [ACTION_W-1:0] in_action_reg;
    logic [PAYLEN_W-1:0] in_paylen_reg;

    // stream state
    phase_t              phase_reg,  phase_next;
    logic [FLAGS_W-1:0]  flags_reg,  flags_next;
    tally_t              tally_reg,  tally_next;
    tally_t              thresh_reg;

    // result register
    logic                out_valid_reg;
    phase_t              out_phase_reg;
    logic                out_ok_reg;
    logic [FLAGS_W-1:0]  out_flags_reg;
    logic                out_hc_reg;
    tally_t              out_tally_reg;
    logic                out_wu_reg;

    logic                advance;
    logic                ok;
    logic                wu;
    logic [TALLY_W:0]    sum;
    tally_t              sum_sat;
    logic                active;

    // pipeline flow control
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    // saturating add of the data payload
    assign sum     = {1'b0, tally_reg} + {{(TALLY_W + 1 - PAYLEN_W){1'b0}}, in_paylen_reg};
    assign sum_sat = sum[TALLY_W] ? TALLY_MAX : sum[TALLY_W-1:0];
    assign active  = (phase_reg >= PH_OPEN) && (phase_reg <= PH_HC_REMOTE);

    // next-state table
    always_comb begin
        phase_next = phase_reg;
        tally_next = tally_reg;
        flags_next = flags_reg;
        ok         = 1'b0;
        wu         = 1'b0;
        unique case (in_action_reg)
            ACT_SEND_HDR: begin
                if (phase_reg == PH_IDLE) begin
                    phase_next = PH_OPEN;
                    ok         = 1'b1;
                end else if (phase_reg == PH_RES_LOCAL) begin
                    phase_next = PH_HC_REMOTE;
                    ok         = 1'b1;
                end
            end
            ACT_RECV_HDR: begin
                if (phase_reg == PH_IDLE) begin
                    phase_next = PH_OPEN;
                    ok         = 1'b1;
                end else if (phase_reg == PH_RES_REMOTE) begin
                    phase_next = PH_HC_LOCAL;
                    ok         = 1'b1;
                end
            end
            ACT_SEND_ENDHDR, ACT_RECV_ENDHDR: begin
                ok = 1'b1;
            end
            ACT_SEND_ENDSTR: begin
                if (phase_reg == PH_OPEN) begin
                    phase_next = PH_HC_LOCAL;
                    ok         = 1'b1;
                end else if (phase_reg == PH_HC_REMOTE) begin
                    phase_next = PH_CLOSED;
                    ok         = 1'b1;
                end
            end
            ACT_RECV_ENDSTR: begin
                if (phase_reg == PH_OPEN) begin
                    phase_next = PH_HC_REMOTE;
                    ok         = 1'b1;
                end else if (phase_reg == PH_HC_LOCAL) begin
                    phase_next = PH_CLOSED;
                    ok         = 1'b1;
                end
            end
            ACT_SEND_RST, ACT_RECV_RST: begin
                if (active) begin
                    phase_next = PH_CLOSED;
                    ok         = 1'b1;
                end
            end
            ACT_DATA: begin
                tally_next = sum_sat;
                wu         = sum_sat > thresh_reg;
                ok         = 1'b1;
            end
            ACT_CLEAR: begin
                tally_next = '0;
                ok         = 1'b1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        // flag bit for accepted stream events
        if (ok && !in_action_reg[ACTION_W-1]) begin
            flags_next[in_action_reg[ACTION_W-2:0]] = 1'b1;
        end
    end

    // input register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_action_reg <= s_action;
            in_paylen_reg <= s_frame_len;
        end
    end

    // stream state and threshold
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            flags_reg  <= '0;
            tally_reg  <= '0;
            thresh_reg <= THRESHOLD_RESET;
        end else begin
            if (advance) begin
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                tally_reg <= tally_next;
            end
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
        end
    end

    // result register control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_phase_reg <= phase_next;
            out_ok_reg    <= ok;
            out_flags_reg <= flags_next;
            out_hc_reg    <= flags_next[FLAG_RECV_ENDHDR] && flags_next[FLAG_RECV_ENDSTR];
            out_tally_reg <= tally_next;
            out_wu_reg    <= wu;
        end
    end

    // result beat
    assign m_valid                = out_valid_reg;
    assign m_stream_state         = out_phase_reg;
    assign m_accepted             = out_ok_reg;
    assign m_event_flags          = out_flags_reg;
    assign m_headers_complete     = out_hc_reg;
    assign m_received_bytes       = out_tally_reg;
    assign m_window_update_needed = out_wu_reg;

endmodule

>>> src/hsst_checker.sv
// port-level checker for the http/2 stream state tracker, with its bind
module hsst_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [hsst_pkg::PHASE_W-1:0]  m_stream_state,
    input logic                          m_accepted,
    input logic [hsst_pkg::FLAGS_W-1:0]  m_event_flags,
    input logic                          m_headers_complete,
    input logic [hsst_pkg::TALLY_W-1:0]  m_received_bytes,
    input logic                          m_window_update_needed
);
    import hsst_pkg::*;

    // no result beat right after reset
    property p_reset_clears_out;
        @(posedge aclk) !aresetn |=> !m_valid;
    endproperty
    a_reset_clears_out: assert property (p_reset_clears_out)
        else $error("result valid after reset");

    // a stalled result beat holds
    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && !m_ready |=> m_valid && $stable(m_stream_state)
                && $stable(m_event_flags) && $stable(m_received_bytes);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled result beat changed");

    // input backpressure only comes from a stalled result
    property p_stall_source;
        @(posedge aclk) disable iff (!aresetn)
            !s_ready |-> m_valid && !m_ready;
    endproperty
    a_stall_source: assert property (p_stall_source)
        else $error("input stalled without output backpressure");

    // headers complete follows the two receive flags
    property p_hc_flags;
        @(posedge aclk) disable iff (!aresetn)
            m_valid |-> m_headers_complete
                == (m_event_flags[FLAG_RECV_ENDHDR] && m_event_flags[FLAG_RECV_ENDSTR]);
    endproperty
    a_hc_flags: assert property (p_hc_flags)
        else $error("headers_complete disagrees with event flags");

    // window update is only requested with a nonzero count
    property p_wu_count;
        @(posedge aclk) disable iff (!aresetn)
            m_valid && m_window_update_needed |-> m_accepted && (m_received_bytes != '0);
    endproperty
    a_wu_count: assert property (p_wu_count)
        else $error("window update with zero byte count");

endmodule

bind http2_stream_state_tracker hsst_checker u_hsst_checker (.*);

>>> bench/http2_stream_state_tracker_tb.sv
// self-checking testbench for the http/2 stream state tracker
module http2_stream_state_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hsst_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 2000;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 4'd10;
    localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 4'd15;
    localparam logic [PAYLEN_W-1:0] LEN_MAX = {PAYLEN_W{1'b1}};

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [PAYLEN_W-1:0] length;
    } frame_t;

    typedef struct packed {
        phase_t               stream_state;
        logic                 accepted;
        logic [FLAGS_W-1:0]   event_flags;
        logic                 headers_complete;
        tally_t               received_bytes;
        logic                 window_update_needed;
    } stream_status_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [ACTION_W-1:0]  s_action = '0;
    logic [PAYLEN_W-1:0]  s_frame_len = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    phase_t               m_stream_state;
    logic                 m_accepted;
    logic [FLAGS_W-1:0]   m_event_flags;
    logic                 m_headers_complete;
    tally_t               m_received_bytes;
    logic                 m_window_update_needed;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    tally_t               cfg_data = '0;

    // mirror of the tracker state and its threshold register
    phase_t               cur_phase = PH_IDLE;
    logic [FLAGS_W-1:0]   seen_mask = '0;
    tally_t               byte_count = '0;
    tally_t               wu_threshold = THRESHOLD_RESET;

    frame_t               frames_to_send[$];
    stream_status_t       statuses_due[$];
    frame_t               next_frame;
    stream_status_t       want;
    int                   send_idle_pct = 15;
    int                   recv_idle_pct = 66;
    logic                 recv_hold = 1'b0;
    int                   failures = 0;
    int                   quiet_cycles = 0;

    http2_stream_state_tracker uut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_action               (s_action),
        .s_frame_len            (s_frame_len),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_stream_state         (m_stream_state),
        .m_accepted             (m_accepted),
        .m_event_flags          (m_event_flags),
        .m_headers_complete     (m_headers_complete),
        .m_received_bytes       (m_received_bytes),
        .m_window_update_needed (m_window_update_needed),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_data               (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // advance the mirrored stream by one frame event and return its status
    function automatic stream_status_t track_event(input logic [ACTION_W-1:0] action,
                                                   input logic [PAYLEN_W-1:0] length);
        phase_t          nxt;
        logic            ok;
        logic            wu;
        logic [31:0]     sum;
        stream_status_t  st;
        nxt = cur_phase;
        ok = 1'b0;
        wu = 1'b0;
        case (action)
            ACT_SEND_HDR: begin
                if (cur_phase == PH_IDLE) begin
                    nxt = PH_OPEN;
                    ok = 1'b1;
                end else if (cur_phase == PH_RES_LOCAL) begin
                    nxt = PH_HC_REMOTE;
                    ok = 1'b1;
                end
            end
            ACT_RECV_HDR: begin
                if (cur_phase == PH_IDLE) begin
                    nxt = PH_OPEN;
                    ok = 1'b1;
                end else if (cur_phase == PH_RES_REMOTE) begin
                    nxt = PH_HC_LOCAL;
                    ok = 1'b1;
                end
            end
            ACT_SEND_ENDHDR, ACT_RECV_ENDHDR: begin
                ok = 1'b1;
            end
            ACT_SEND_ENDSTR: begin
                if (cur_phase == PH_OPEN) begin
                    nxt = PH_HC_LOCAL;
                    ok = 1'b1;
                end else if (cur_phase == PH_HC_REMOTE) begin
                    nxt = PH_CLOSED;
                    ok = 1'b1;
                end
            end
            ACT_RECV_ENDSTR: begin
                if (cur_phase == PH_OPEN) begin
                    nxt = PH_HC_REMOTE;
                    ok = 1'b1;
                end else if (cur_phase == PH_HC_LOCAL) begin
                    nxt = PH_CLOSED;
                    ok = 1'b1;
                end
            end
            ACT_SEND_RST, ACT_RECV_RST: begin
                // any active stream closes
                if (cur_phase >= PH_OPEN && cur_phase <= PH_HC_REMOTE) begin
                    nxt = PH_CLOSED;
                    ok = 1'b1;
                end
            end
            ACT_DATA: begin
                // saturating add, then compare against the threshold
                sum = {1'b0, byte_count} + {8'b0, length};
                if (sum > {1'b0, TALLY_MAX}) begin
                    byte_count = TALLY_MAX;
                end else begin
                    byte_count = sum[TALLY_W-1:0];
                end
                wu = byte_count > wu_threshold;
                ok = 1'b1;
            end
            ACT_CLEAR: begin
                byte_count = '0;
                ok = 1'b1;
            end
            default: begin
            end
        endcase
        if (ok && action < ACT_DATA) begin
            seen_mask[action[2:0]] = 1'b1;
        end
        cur_phase = nxt;
        st.stream_state = cur_phase;
        st.accepted = ok;
        st.event_flags = seen_mask;
        st.headers_complete = seen_mask[FLAG_RECV_ENDHDR] && seen_mask[FLAG_RECV_ENDSTR];
        st.received_bytes = byte_count;
        st.window_update_needed = wu;
        return st;
    endfunction

    function automatic void check_field(input string label, input logic [31:0] exp_val,
                                        input logic [31:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, exp_val,
                     got_val);
            failures++;
        end
    endfunction

    // sender: takes beats from the pending queue, predicts each accepted one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                statuses_due.push_back(track_event(s_action, s_frame_len));
            end
            if (!s_valid || s_ready) begin
                if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_frame = frames_to_send.pop_front();
                    s_valid <= 1'b1;
                    s_action <= next_frame.action;
                    s_frame_len <= next_frame.length;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: compares each result beat with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (statuses_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, state %0d", $time,
                             m_stream_state);
                    failures++;
                end else begin
                    want = statuses_due.pop_front();
                    check_field("stream_state", 32'(want.stream_state),
                                32'(m_stream_state));
                    check_field("accepted", 32'(want.accepted), 32'(m_accepted));
                    check_field("event_flags", 32'(want.event_flags), 32'(m_event_flags));
                    check_field("headers_complete", 32'(want.headers_complete),
                                32'(m_headers_complete));
                    check_field("received_bytes", 32'(want.received_bytes),
                                32'(m_received_bytes));
                    check_field("window_update_needed", 32'(want.window_update_needed),
                                32'(m_window_update_needed));
                end
            end
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding", $time,
                     quiet_cycles, statuses_due.size());
            $display("http2_stream_state_tracker_tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_frame(input logic [ACTION_W-1:0] act, input logic [PAYLEN_W-1:0] len);
        frame_t f;
        f.action = act;
        f.length = len;
        frames_to_send.push_back(f);
    endtask

    // random beats; bulk mode favors long data frames and never clears
    task automatic queue_random(input int count, input bit bulk);
        frame_t f;
        int     pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < (bulk ? 85 : 45)) begin
                f.action = ACT_DATA;
            end else if (!bulk && pick < 55) begin
                f.action = ACT_CLEAR;
            end else begin
                f.action = ACTION_W'($urandom_range(15));
                if (bulk && f.action == ACT_CLEAR) begin
                    f.action = ACT_DATA;
                end
            end
            case ($urandom_range(bulk ? 1 : 4))
                0: f.length = LEN_MAX;
                1: f.length = PAYLEN_W'($urandom_range(LEN_MAX));
                2: f.length = '0;
                default: f.length = PAYLEN_W'($urandom_range(50000));
            endcase
            frames_to_send.push_back(f);
        end
    endtask

    // wait for every beat to be sent and answered, then for the pipeline
    task automatic drain();
        do begin
            @(negedge aclk);
        end while (frames_to_send.size() != 0 || s_valid || statuses_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic set_threshold(input tally_t value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        wu_threshold = value;
    endtask

    initial begin
        logic [ACTION_W-1:0] opener;
        logic [ACTION_W-1:0] half;
        logic [ACTION_W-1:0] closer;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed walk at the reset threshold; the path through the states is random
        opener = $urandom_range(1) ? ACT_RECV_HDR : ACT_SEND_HDR;
        half = $urandom_range(1) ? ACT_SEND_ENDSTR : ACT_RECV_ENDSTR;
        case ($urandom_range(2))
            0: closer = (half == ACT_SEND_ENDSTR) ? ACT_RECV_ENDSTR : ACT_SEND_ENDSTR;
            1: closer = ACT_SEND_RST;
            default: closer = ACT_RECV_RST;
        endcase
        // illegal events while idle, unused codes, threshold edge
        push_frame(ACT_SEND_ENDSTR, '0);
        push_frame(ACT_RECV_RST, '0);
        push_frame(ACT_SEND_RST, LEN_MAX);
        push_frame(ACT_UNUSED_LO, LEN_MAX);
        push_frame(ACT_UNUSED_HI, '0);
        push_frame(ACT_DATA, '0);
        push_frame(ACT_DATA, 24'd30000);
        push_frame(ACT_DATA, 24'd1);
        push_frame(ACT_CLEAR, LEN_MAX);
        // open, then headers again are illegal
        push_frame(opener, '0);
        push_frame(ACT_SEND_HDR, '0);
        push_frame(ACT_RECV_HDR, '0);
        push_frame(ACT_RECV_ENDHDR, '0);
        push_frame(ACT_SEND_ENDHDR, '0);
        // half close, the same end-stream again is illegal
        push_frame(half, '0);
        push_frame(half, '0);
        push_frame(ACT_DATA, LEN_MAX);
        push_frame(closer, '0);
        // closed stream ignores every transition
        push_frame(ACT_SEND_RST, '0);
        push_frame(ACT_RECV_RST, '0);
        push_frame(ACT_SEND_ENDSTR, '0);
        push_frame(ACT_RECV_HDR, '0);
        push_frame(ACT_CLEAR, '0);
        queue_random(330, 1'b0);
        drain();

        // highest threshold, counter driven into saturation, long receiver hold-off
        set_threshold(TALLY_MAX);
        @(negedge aclk);
        send_idle_pct <= 66;
        recv_idle_pct <= 15;
        queue_random(400, 1'b1);
        recv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge aclk);
        recv_hold <= 1'b0;
        drain();

        // one below the saturated count, then zero, then a small random value
        set_threshold(TALLY_MAX - 1'b1);
        @(negedge aclk);
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        queue_random(150, 1'b0);
        drain();

        set_threshold('0);
        @(negedge aclk);
        queue_random(120, 1'b0);
        drain();

        set_threshold(tally_t'($urandom_range(2000000)));
        @(negedge aclk);
        queue_random(120, 1'b0);
        drain();

        if (failures == 0 && statuses_due.size() == 0) begin
            $display("http2_stream_state_tracker_tb OK");
        end else begin
            $display("http2_stream_state_tracker_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/hsst_pkg.sv
src/http2_stream_state_tracker.sv
src/hsst_checker.sv
bench/http2_stream_state_tracker_tb.sv
